[sv/glyph_quad_layout_macros.svh]
// Assertion macros for the glyph quad layout block.
// Used by the checker only; expects clk_i and rst_ni in the calling scope.
`ifndef GLYPH_QUAD_LAYOUT_MACROS_SVH
`define GLYPH_QUAD_LAYOUT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define GLQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define GLQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/glq_pkg.sv]
// Shared types, constants and saturation helpers for the glyph quad layout.
// No dependencies; used by the interfaces, the top level, the checker and the testbench.
package glq_pkg;

  // Sizing
  localparam int GLYPH_COUNT = 128;
  localparam int GLYPH_AW    = $clog2(GLYPH_COUNT);
  localparam int TEX_AW      = GLYPH_AW + 2;
  localparam int MAX_QUADS   = 1024;
  localparam int QUAD_W      = $clog2(MAX_QUADS + 1);
  localparam int COORD_W     = 20;
  localparam int WIDE_W      = COORD_W + 3;
  localparam int SLOT_W      = 12;
  localparam int METRIC_W    = 16;
  localparam int UV_W        = 16;
  localparam int COLOR_W     = 32;
  localparam int LINE_W      = 19;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [LINE_W-1:0] NO_WRAP = {LINE_W{1'b1}};

  // Register reset values
  localparam logic [COLOR_W-1:0]  TEXT_COLOR_RST  = {COLOR_W{1'b1}};
  localparam logic [METRIC_W-1:0] FONT_HEIGHT_RST = METRIC_W'(256);
  localparam logic [METRIC_W-1:0] SPACE_WIDTH_RST = METRIC_W'(64);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;

  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_SET_PEN  = 3'd1,
    CMD_METRIC   = 3'd2,
    CMD_TEXCOORD = 3'd3,
    CMD_CHAR     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_VERTEX   = 2'd0,
    ST_BAD_CODE = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXT_COLOR  = 2'd0,
    REG_FONT_HEIGHT = 2'd1,
    REG_LINE_WIDTH  = 2'd2,
    REG_SPACE_WIDTH = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [METRIC_W-1:0] w;
    logic [METRIC_W-1:0] h;
    logic [METRIC_W-1:0] adv;
    logic [METRIC_W-1:0] drop;
  } metric_t;

  typedef struct packed {
    logic [UV_W-1:0] u;
    logic [UV_W-1:0] v;
  } uv_t;

  // Sign-extend a coordinate into the wide working format
  function automatic wide_t widen(coord_t c);
    return $signed({{(WIDE_W-COORD_W){c[COORD_W-1]}}, c});
  endfunction

  // Zero-extend an unsigned metric into the wide working format
  function automatic wide_t uwiden(logic [METRIC_W-1:0] m);
    return $signed({{(WIDE_W-METRIC_W){1'b0}}, m});
  endfunction

  // Clamp a wide value to the signed coordinate range
  function automatic coord_t sat_coord(wide_t v);
    logic fits;
    fits = (&v[WIDE_W-1:COORD_W-1]) || (~|v[WIDE_W-1:COORD_W-1]);
    if (fits) begin
      return v[COORD_W-1:0];
    end
    return v[WIDE_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

endpackage

[sv/glq_ifs.sv]
// Valid/ready channel interfaces for character commands and vertex results.
// Depends on glq_pkg for field types.
interface glq_in_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     command;
  logic [7:0]                     char_code;
  glq_pkg::coord_t                pen_x;
  glq_pkg::coord_t                pen_y;
  logic [glq_pkg::METRIC_W-1:0]   glyph_width;
  logic [glq_pkg::METRIC_W-1:0]   glyph_height;
  logic [glq_pkg::METRIC_W-1:0]   glyph_advance;
  logic [glq_pkg::METRIC_W-1:0]   glyph_drop;
  logic [1:0]                     corner;
  logic [glq_pkg::UV_W-1:0]       tex_u_in;
  logic [glq_pkg::UV_W-1:0]       tex_v_in;

  modport source (
    output valid, command, char_code, pen_x, pen_y, glyph_width, glyph_height,
           glyph_advance, glyph_drop, corner, tex_u_in, tex_v_in,
    input  ready
  );
  modport sink (
    input  valid, command, char_code, pen_x, pen_y, glyph_width, glyph_height,
           glyph_advance, glyph_drop, corner, tex_u_in, tex_v_in,
    output ready
  );
endinterface

interface glq_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [glq_pkg::SLOT_W-1:0]    vertex_slot;
  glq_pkg::coord_t               pos_x;
  glq_pkg::coord_t               pos_y;
  logic [glq_pkg::UV_W-1:0]      tex_u;
  logic [glq_pkg::UV_W-1:0]      tex_v;
  logic [glq_pkg::COLOR_W-1:0]   color;
  logic                          last;

  modport source (
    output valid, status, vertex_slot, pos_x, pos_y, tex_u, tex_v, color, last,
    input  ready
  );
  modport sink (
    input  valid, status, vertex_slot, pos_x, pos_y, tex_u, tex_v, color, last,
    output ready
  );
endinterface

[sv/glq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module glq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/glyph_quad_layout.sv]
// Glyph quad layout top level: pen state, glyph tables and vertex sequencer.
// Depends on glq_pkg, glq_ifs (channels) and glq_ram (metric and UV tables).
//
// Text layout engine. Commands clear the buffer, move the pen, load glyph
// metrics and corner UVs, or place a character. A placed glyph produces four
// vertices, one per cycle unless the output stalls; the limit is the UV table's
// single read port, read once per corner. Error and buffer-full statuses give
// a single result; items with no result (clear, set pen, metric loads, spaces,
// newlines) bypass the sequencer, overlapping the vertices of an earlier glyph;
// a UV load waits until the sequencer issues its last corner. A character passes
// the decode register, sequencer, vertex stage and output register before its
// first vertex appears. A result waiting at the output does not block the next
// transaction until the sequencer itself backs up. Configuration registers are
// written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must write them only while idle (not enforced).
module glyph_quad_layout (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [glq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [glq_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  glq_in_if.sink                          in_i,
  glq_out_if.source                       out_o
);

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [glq_pkg::COLOR_W-1:0]  text_color_q;
  logic [glq_pkg::METRIC_W-1:0] font_height_q;
  logic [glq_pkg::LINE_W-1:0]   line_width_q;
  logic [glq_pkg::METRIC_W-1:0] space_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q  <= glq_pkg::TEXT_COLOR_RST;
      font_height_q <= glq_pkg::FONT_HEIGHT_RST;
      line_width_q  <= glq_pkg::NO_WRAP;
      space_width_q <= glq_pkg::SPACE_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (glq_pkg::cfg_idx_e'(cfg_idx_i))
        glq_pkg::REG_TEXT_COLOR:  text_color_q  <= cfg_wdata_i[glq_pkg::COLOR_W-1:0];
        glq_pkg::REG_FONT_HEIGHT: font_height_q <= cfg_wdata_i[glq_pkg::METRIC_W-1:0];
        glq_pkg::REG_LINE_WIDTH:  line_width_q  <= cfg_wdata_i[glq_pkg::LINE_W-1:0];
        glq_pkg::REG_SPACE_WIDTH: space_width_q <= cfg_wdata_i[glq_pkg::METRIC_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake signals between stages
  logic in_accept;
  logic b_valid_q, b_fire, b_needs_em;
  logic em_valid_q, em_issue, em_last, em_can_load, em_load;
  logic e2_valid_q, e2_free;
  logic out_valid_q, out_free;

  assign in_accept = in_i.valid && in_i.ready;
  assign in_i.ready = !b_valid_q || b_fire;

  // ---------------------------------------------------------------------
  // Metric table: written and read at acceptance
  glq_pkg::metric_t metric_wdata, metric_rdata;
  logic             metric_we;

  assign metric_we = in_accept && (glq_pkg::cmd_e'(in_i.command) == glq_pkg::CMD_METRIC) &&
                     ({1'b0, in_i.char_code} < 9'(glq_pkg::GLYPH_COUNT));
  assign metric_wdata = '{w: in_i.glyph_width, h: in_i.glyph_height,
                          adv: in_i.glyph_advance, drop: in_i.glyph_drop};

  glq_ram #(
    .WIDTH ($bits(glq_pkg::metric_t)),
    .DEPTH (glq_pkg::GLYPH_COUNT)
  ) u_metric_ram (
    .clk_i   (clk_i),
    .we_i    (metric_we),
    .waddr_i (in_i.char_code[glq_pkg::GLYPH_AW-1:0]),
    .wdata_i (metric_wdata),
    .re_i    (in_accept),
    .raddr_i (in_i.char_code[glq_pkg::GLYPH_AW-1:0]),
    .rdata_o (metric_rdata)
  );

  // ---------------------------------------------------------------------
  // Decode stage register (holds the transaction while metrics are read)
  glq_pkg::cmd_e            b_cmd_q;
  logic [7:0]               b_code_q;
  glq_pkg::coord_t          b_pen_x_q, b_pen_y_q;
  logic [1:0]               b_corner_q;
  logic [glq_pkg::UV_W-1:0] b_u_q, b_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (in_accept) begin
      b_valid_q <= 1'b1;
    end else if (b_fire) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      b_cmd_q    <= glq_pkg::cmd_e'(in_i.command);
      b_code_q   <= in_i.char_code;
      b_pen_x_q  <= in_i.pen_x;
      b_pen_y_q  <= in_i.pen_y;
      b_corner_q <= in_i.corner;
      b_u_q      <= in_i.tex_u_in;
      b_v_q      <= in_i.tex_v_in;
    end
  end

  // ---------------------------------------------------------------------
  // Pen and quad state
  glq_pkg::coord_t           pen_x_q, pen_x_d, pen_y_q, pen_y_d;
  logic [glq_pkg::QUAD_W-1:0] quad_q, quad_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q <= '0;
      pen_y_q <= '0;
      quad_q  <= '0;
    end else begin
      pen_x_q <= pen_x_d;
      pen_y_q <= pen_y_d;
      quad_q  <= quad_d;
    end
  end

  // ---------------------------------------------------------------------
  // Character geometry
  logic            is_full, is_space, is_newline, is_bad, too_wide, wrap;
  logic            b_emit, tex_we;
  glq_pkg::wide_t  px_w, bot_raw;
  glq_pkg::coord_t x0, x1, y0, top, bot, adv_x, space_x;
  glq_pkg::status_e em_status_d;

  always_comb begin
    is_full    = quad_q >= glq_pkg::QUAD_W'(glq_pkg::MAX_QUADS);
    is_space   = b_code_q == glq_pkg::CH_SPACE;
    is_newline = b_code_q == glq_pkg::CH_NEWLINE;
    is_bad     = {1'b0, b_code_q} >= 9'(glq_pkg::GLYPH_COUNT);
    px_w       = glq_pkg::widen(pen_x_q);
    too_wide   = (line_width_q != glq_pkg::NO_WRAP) &&
                 (px_w + glq_pkg::uwiden(metric_rdata.adv) >=
                  $signed({{(glq_pkg::WIDE_W-glq_pkg::LINE_W){1'b0}}, line_width_q}));
    wrap       = too_wide || is_newline;
    x0         = wrap ? '0 : pen_x_q;
    y0         = wrap ? glq_pkg::sat_coord(glq_pkg::widen(pen_y_q) -
                                           glq_pkg::uwiden(font_height_q))
                      : pen_y_q;
    x1         = glq_pkg::sat_coord(glq_pkg::widen(x0) + glq_pkg::uwiden(metric_rdata.w));
    bot_raw    = glq_pkg::widen(y0) - glq_pkg::uwiden(metric_rdata.drop);
    top        = glq_pkg::sat_coord(bot_raw + glq_pkg::uwiden(metric_rdata.h));
    bot        = glq_pkg::sat_coord(bot_raw);
    adv_x      = glq_pkg::sat_coord(glq_pkg::widen(x0) + glq_pkg::uwiden(metric_rdata.adv));
    space_x    = glq_pkg::sat_coord(px_w + glq_pkg::uwiden(space_width_q));
  end

  // Decode-stage firing: result-producing items and UV writes need the sequencer
  assign b_emit = (b_cmd_q == glq_pkg::CMD_CHAR) &&
                  (is_full || (!is_space && (is_bad || !is_newline)));
  assign b_needs_em = b_emit || (b_cmd_q == glq_pkg::CMD_TEXCOORD);
  assign b_fire = b_valid_q && (!b_needs_em || em_can_load);

  // State update per command
  always_comb begin
    pen_x_d     = pen_x_q;
    pen_y_d     = pen_y_q;
    quad_d      = quad_q;
    em_load     = 1'b0;
    em_status_d = glq_pkg::ST_VERTEX;
    tex_we      = 1'b0;
    if (b_fire) begin
      unique case (b_cmd_q)
        glq_pkg::CMD_CLEAR: begin
          pen_x_d = '0;
          pen_y_d = '0;
          quad_d  = '0;
        end
        glq_pkg::CMD_SET_PEN: begin
          pen_x_d = b_pen_x_q;
          pen_y_d = b_pen_y_q;
        end
        glq_pkg::CMD_METRIC: ;
        glq_pkg::CMD_TEXCOORD: begin
          tex_we = !is_bad;
        end
        glq_pkg::CMD_CHAR: begin
          if (is_full) begin
            em_load     = 1'b1;
            em_status_d = glq_pkg::ST_FULL;
          end else if (is_space) begin
            pen_x_d = space_x;
          end else if (is_bad) begin
            em_load     = 1'b1;
            em_status_d = glq_pkg::ST_BAD_CODE;
          end else if (is_newline) begin
            pen_x_d = x0;
            pen_y_d = y0;
          end else begin
            pen_x_d = adv_x;
            pen_y_d = y0;
            quad_d  = quad_q + glq_pkg::QUAD_W'(1);
            em_load = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Vertex sequencer: one corner per cycle while the vertex stage is free, through the UV table read port
  logic [1:0]                   em_k_q;
  glq_pkg::status_e             em_status_q;
  logic [glq_pkg::GLYPH_AW-1:0] em_code_q;
  logic [glq_pkg::QUAD_W-1:0]   em_quad_q;
  glq_pkg::coord_t              em_x0_q, em_x1_q, em_top_q, em_bot_q;

  assign em_last     = (em_status_q != glq_pkg::ST_VERTEX) || (em_k_q == 2'd3);
  assign em_issue    = em_valid_q && e2_free;
  assign em_can_load = !em_valid_q || (em_issue && em_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q <= 1'b0;
      em_k_q     <= '0;
    end else if (em_load) begin
      em_valid_q <= 1'b1;
      em_k_q     <= '0;
    end else if (em_issue) begin
      if (em_last) begin
        em_valid_q <= 1'b0;
      end
      em_k_q <= em_k_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (em_load) begin
      em_status_q <= em_status_d;
      em_code_q   <= b_code_q[glq_pkg::GLYPH_AW-1:0];
      em_quad_q   <= quad_q;
      em_x0_q     <= x0;
      em_x1_q     <= x1;
      em_top_q    <= top;
      em_bot_q    <= bot;
    end
  end

  // UV table: written from the decode stage, read by the sequencer
  glq_pkg::uv_t tex_wdata, tex_rdata;
  assign tex_wdata = '{u: b_u_q, v: b_v_q};

  glq_ram #(
    .WIDTH ($bits(glq_pkg::uv_t)),
    .DEPTH (glq_pkg::GLYPH_COUNT * 4)
  ) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (tex_we),
    .waddr_i ({b_code_q[glq_pkg::GLYPH_AW-1:0], b_corner_q}),
    .wdata_i (tex_wdata),
    .re_i    (em_issue),
    .raddr_i ({em_code_q, em_k_q}),
    .rdata_o (tex_rdata)
  );

  // ---------------------------------------------------------------------
  // Vertex stage aligned with the UV read data
  glq_pkg::status_e           e2_status_q;
  logic [glq_pkg::SLOT_W-1:0] e2_slot_q;
  glq_pkg::coord_t            e2_x_q, e2_y_q;
  logic                       e2_last_q;
  logic                       em_is_vtx;

  assign e2_free   = !e2_valid_q || out_free;
  assign em_is_vtx = em_status_q == glq_pkg::ST_VERTEX;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2_valid_q <= 1'b0;
    end else if (em_issue) begin
      e2_valid_q <= 1'b1;
    end else if (out_free) begin
      e2_valid_q <= 1'b0;
    end
  end

  // Corner order: top-left, top-right, bottom-right, bottom-left
  always_ff @(posedge clk_i) begin
    if (em_issue) begin
      e2_status_q <= em_status_q;
      e2_last_q   <= em_last;
      if (em_is_vtx) begin
        e2_slot_q <= glq_pkg::SLOT_W'({em_quad_q, em_k_q});
        e2_x_q    <= (em_k_q[0] ^ em_k_q[1]) ? em_x1_q : em_x0_q;
        e2_y_q    <= em_k_q[1] ? em_bot_q : em_top_q;
      end else begin
        e2_slot_q <= '0;
        e2_x_q    <= '0;
        e2_y_q    <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  logic [glq_pkg::SLOT_W-1:0]  out_slot_q;
  glq_pkg::status_e            out_status_q;
  glq_pkg::coord_t             out_x_q, out_y_q;
  logic [glq_pkg::UV_W-1:0]    out_u_q, out_v_q;
  logic [glq_pkg::COLOR_W-1:0] out_color_q;
  logic                        out_last_q;
  logic                        e2_is_vtx;

  assign out_free  = !out_valid_q || out_o.ready;
  assign e2_is_vtx = e2_status_q == glq_pkg::ST_VERTEX;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (e2_valid_q && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e2_valid_q && out_free) begin
      out_status_q <= e2_status_q;
      out_slot_q   <= e2_slot_q;
      out_x_q      <= e2_x_q;
      out_y_q      <= e2_y_q;
      out_u_q      <= e2_is_vtx ? tex_rdata.u : '0;
      out_v_q      <= e2_is_vtx ? tex_rdata.v : '0;
      out_color_q  <= e2_is_vtx ? text_color_q : '0;
      out_last_q   <= e2_last_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.vertex_slot = out_slot_q;
  assign out_o.pos_x       = out_x_q;
  assign out_o.pos_y       = out_y_q;
  assign out_o.tex_u       = out_u_q;
  assign out_o.tex_v       = out_v_q;
  assign out_o.color       = out_color_q;
  assign out_o.last        = out_last_q;

endmodule

[sv/glq_checker.sv]
// Port-level checks for glyph_quad_layout, attached by bind.
// Depends on glq_pkg and glyph_quad_layout_macros.svh.
`include "glyph_quad_layout_macros.svh"

module glq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_status,
  input logic [glq_pkg::SLOT_W-1:0] out_slot,
  input logic                       out_last
);

  // A stalled result stays offered
  `GLQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // Status results are single-transaction items
  `GLQ_ASSERT_NOW(a_status_last, out_valid && (out_status != glq_pkg::ST_VERTEX), out_last, "status result without last")

  // Only the fourth corner of a quad closes the item
  `GLQ_ASSERT_NOW(a_corner_last, out_valid && (out_status == glq_pkg::ST_VERTEX), out_last == (out_slot[1:0] == 2'd3), "last flag does not match corner")

  // Corners of one quad follow back to back
  `GLQ_ASSERT_NEXT(a_corner_run, out_valid && out_ready && !out_last, out_valid && (out_slot[1:0] == $past(out_slot[1:0]) + 2'd1), "gap or skip inside a quad")

endmodule

bind glyph_quad_layout glq_checker u_glq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_status (out_o.status),
  .out_slot   (out_o.vertex_slot),
  .out_last   (out_o.last)
);

[bench/tb_glyph_quad_layout.sv]
// Self-checking testbench for glyph_quad_layout: table loads, pen moves, wraps and vertices.
// Depends on glq_pkg and the glq_in_if/glq_out_if channel interfaces of the RTL.
module tb_glyph_quad_layout;
  import glq_pkg::*;

  localparam int SETTLE_CYCLES = 12;    // extra wait once every vertex is back
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int WATCHDOG_MAX  = 4000;  // cycles without any transaction
  localparam int PHASE_ITEMS   = 30;
  localparam int MAX_PRINTS    = 40;
  localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;
  localparam logic [7:0] GLYPH_A    = 8'd65;
  localparam logic [7:0] GLYPH_HUGE = 8'd127;
  localparam longint COORD_HI = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;

  typedef struct {
    logic [2:0]          command;
    logic [7:0]          code;
    coord_t              px;
    coord_t              py;
    logic [METRIC_W-1:0] w;
    logic [METRIC_W-1:0] h;
    logic [METRIC_W-1:0] adv;
    logic [METRIC_W-1:0] drop;
    logic [1:0]          corner;
    logic [UV_W-1:0]     u;
    logic [UV_W-1:0]     v;
  } glyph_cmd_t;

  typedef struct {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot;
    coord_t             x;
    coord_t             y;
    logic [UV_W-1:0]    u;
    logic [UV_W-1:0]    v;
    logic [COLOR_W-1:0] color;
    logic               last;
  } vertex_t;

  typedef struct {
    glyph_cmd_t c;
    bit         typed;
    status_e    st;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  glq_in_if  glyph_in ();
  glq_out_if vtx_out ();

  glyph_quad_layout u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (glyph_in),
    .out_o       (vtx_out)
  );

  // Shadow of the block: configuration, pen, quad count and glyph tables
  logic [COLOR_W-1:0]  text_color = TEXT_COLOR_RST;
  logic [METRIC_W-1:0] font_h     = FONT_HEIGHT_RST;
  logic [LINE_W-1:0]   line_w     = NO_WRAP;
  logic [METRIC_W-1:0] space_w    = SPACE_WIDTH_RST;
  coord_t              pen_x      = '0;
  coord_t              pen_y      = '0;
  int                  quads      = 0;
  metric_t             glyph_metrics [GLYPH_COUNT];
  uv_t                 glyph_uvs [GLYPH_COUNT*4];
  bit                  metric_set [GLYPH_COUNT];
  logic [3:0]          uv_set [GLYPH_COUNT];

  vertex_t pending_vertices[$];
  int      mismatch_count = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  bit      hold_req       = 1'b0;
  int      idle_cycles    = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic note_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("%0t: %s differs, got %0d expected %0d", $time, what, got, want);
    end
  endtask

  function automatic coord_t clamp_coord(input longint v);
    if (v > COORD_HI) return coord_t'(COORD_HI);
    if (v < COORD_LO) return coord_t'(COORD_LO);
    return coord_t'(v);
  endfunction

  function automatic bit placeable(input logic [7:0] code);
    if (code >= GLYPH_COUNT || code == CH_SPACE || code == CH_NEWLINE) return 1'b0;
    return metric_set[code] && (uv_set[code] == 4'hF);
  endfunction

  // Expected vertices of one transaction; updates the shadow state
  function automatic void layout_step(input glyph_cmd_t c, ref vertex_t res[$]);
    metric_t m;
    longint  x0, x1, bot, top;
    logic    too_wide;
    coord_t  xs[4];
    coord_t  ys[4];
    int      idx;
    case (c.command)
      CMD_CLEAR: begin
        quads = 0;
        pen_x = '0;
        pen_y = '0;
      end
      CMD_SET_PEN: begin
        pen_x = c.px;
        pen_y = c.py;
      end
      CMD_METRIC: begin
        if (c.code < GLYPH_COUNT) begin
          glyph_metrics[c.code] = '{c.w, c.h, c.adv, c.drop};
          metric_set[c.code] = 1'b1;
        end
      end
      CMD_TEXCOORD: begin
        if (c.code < GLYPH_COUNT) begin
          glyph_uvs[c.code*4 + c.corner] = '{c.u, c.v};
          uv_set[c.code][c.corner] = 1'b1;
        end
      end
      CMD_CHAR: begin
        if (quads >= MAX_QUADS) begin
          res.push_back('{ST_FULL, '0, '0, '0, '0, '0, '0, 1'b1});
        end else if (c.code == CH_SPACE) begin
          pen_x = clamp_coord(longint'(pen_x) + longint'(space_w));
        end else if (c.code >= GLYPH_COUNT) begin
          res.push_back('{ST_BAD_CODE, '0, '0, '0, '0, '0, '0, 1'b1});
        end else begin
          m = glyph_metrics[c.code];
          too_wide = (line_w != NO_WRAP) &&
                     (longint'(pen_x) + longint'(m.adv) >= longint'(line_w));
          if (too_wide || c.code == CH_NEWLINE) begin
            pen_x = '0;
            pen_y = clamp_coord(longint'(pen_y) - longint'(font_h));
          end
          if (c.code != CH_NEWLINE) begin
            // top is taken from the unclamped bottom edge
            x0  = longint'(pen_x);
            x1  = clamp_coord(x0 + longint'(m.w));
            bot = longint'(pen_y) - longint'(m.drop);
            top = clamp_coord(bot + longint'(m.h));
            xs  = '{coord_t'(x0), coord_t'(x1), coord_t'(x1), coord_t'(x0)};
            ys  = '{coord_t'(top), coord_t'(top), clamp_coord(bot), clamp_coord(bot)};
            for (int k = 0; k < 4; k++) begin
              idx = c.code*4 + k;
              res.push_back('{ST_VERTEX, SLOT_W'(quads*4 + k), xs[k], ys[k],
                              glyph_uvs[idx].u, glyph_uvs[idx].v, text_color, k == 3});
            end
            pen_x = clamp_coord(longint'(pen_x) + longint'(m.adv));
            quads++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Command builders; fields a command does not use carry random bits
  function automatic glyph_cmd_t rand_fields();
    glyph_cmd_t c;
    c.command = CMD_CHAR;
    c.code    = 8'($urandom());
    c.px      = coord_t'($urandom());
    c.py      = coord_t'($urandom());
    c.w       = METRIC_W'($urandom());
    c.h       = METRIC_W'($urandom());
    c.adv     = METRIC_W'($urandom());
    c.drop    = METRIC_W'($urandom());
    c.corner  = 2'($urandom());
    c.u       = UV_W'($urandom());
    c.v       = UV_W'($urandom());
    return c;
  endfunction

  function automatic glyph_cmd_t bare_cmd(input logic [2:0] cmd);
    glyph_cmd_t c;
    c = rand_fields();
    c.command = cmd;
    return c;
  endfunction

  function automatic glyph_cmd_t char_cmd(input logic [7:0] code);
    glyph_cmd_t c;
    c = bare_cmd(CMD_CHAR);
    c.code = code;
    return c;
  endfunction

  function automatic glyph_cmd_t metric_cmd(input logic [7:0] code,
      input logic [METRIC_W-1:0] w, h, adv, drop);
    glyph_cmd_t c;
    c = bare_cmd(CMD_METRIC);
    c.code = code;
    c.w    = w;
    c.h    = h;
    c.adv  = adv;
    c.drop = drop;
    return c;
  endfunction

  function automatic glyph_cmd_t uv_cmd(input logic [7:0] code, input logic [1:0] corner,
      input logic [UV_W-1:0] u, v);
    glyph_cmd_t c;
    c = bare_cmd(CMD_TEXCOORD);
    c.code   = code;
    c.corner = corner;
    c.u      = u;
    c.v      = v;
    return c;
  endfunction

  function automatic glyph_cmd_t pen_cmd(input coord_t x, input coord_t y);
    glyph_cmd_t c;
    c = bare_cmd(CMD_SET_PEN);
    c.px = x;
    c.py = y;
    return c;
  endfunction

  // Mostly modest metrics so the pen does not pin at the rails
  function automatic logic [METRIC_W-1:0] rand_metric();
    if ($urandom_range(0, 99) < 85) return METRIC_W'($urandom_range(0, 16'h0300));
    return METRIC_W'($urandom());
  endfunction

  function automatic logic [7:0] pick_glyph();
    logic [7:0] c;
    for (int t = 0; t < 64; t++) begin
      c = 8'($urandom_range(0, GLYPH_COUNT - 1));
      if (placeable(c)) return c;
    end
    return GLYPH_A;
  endfunction

  // One input transaction, with random sender gaps ahead of it
  task automatic send_item(input glyph_cmd_t c, input bit typed = 1'b0,
                           input status_e typed_st = ST_VERTEX);
    vertex_t res[$];
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      glyph_in.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    glyph_in.valid         <= 1'b1;
    glyph_in.command       <= c.command;
    glyph_in.char_code     <= c.code;
    glyph_in.pen_x         <= c.px;
    glyph_in.pen_y         <= c.py;
    glyph_in.glyph_width   <= c.w;
    glyph_in.glyph_height  <= c.h;
    glyph_in.glyph_advance <= c.adv;
    glyph_in.glyph_drop    <= c.drop;
    glyph_in.corner        <= c.corner;
    glyph_in.tex_u_in      <= c.u;
    glyph_in.tex_v_in      <= c.v;
    do @(posedge clk); while (glyph_in.ready !== 1'b1);
    layout_step(c, res);
    if (typed) begin
      pending_vertices.push_back('{typed_st, '0, '0, '0, '0, '0, '0, 1'b1});
    end else begin
      foreach (res[i]) pending_vertices.push_back(res[i]);
    end
  endtask

  task automatic define_glyph(input logic [7:0] code);
    send_item(metric_cmd(code, rand_metric(), rand_metric(), rand_metric(), rand_metric()));
    for (int k = 0; k < 4; k++) begin
      send_item(uv_cmd(code, 2'(k), UV_W'($urandom()), UV_W'($urandom())));
    end
  endtask

  // Random transaction mix; returns how many items count toward the phase
  task automatic send_random(output int counted);
    int         r;
    logic [7:0] code;
    r = $urandom_range(0, 99);
    counted = 1;
    if (r < 45) begin
      send_item(char_cmd(pick_glyph()));
    end else if (r < 55) begin
      send_item(char_cmd(CH_SPACE));
    end else if (r < 62) begin
      send_item(char_cmd(CH_NEWLINE));
    end else if (r < 67) begin
      send_item(char_cmd(8'($urandom_range(GLYPH_COUNT, 255))));
    end else if (r < 75) begin
      define_glyph(8'($urandom_range(0, GLYPH_COUNT - 1)));
      counted = 5;
    end else if (r < 85) begin
      code = 8'($urandom());
      send_item(uv_cmd(code, 2'($urandom()), UV_W'($urandom()), UV_W'($urandom())));
      counted = (code < GLYPH_COUNT);
    end else if (r < 87) begin
      // table write past the end of the table is dropped
      code = 8'($urandom_range(GLYPH_COUNT, 255));
      send_item(metric_cmd(code, rand_metric(), rand_metric(), rand_metric(), rand_metric()));
      counted = 0;
    end else if (r < 93) begin
      if ($urandom_range(0, 1)) begin
        send_item(pen_cmd(coord_t'(int'($urandom_range(0, 65535)) - 32768),
                          coord_t'(int'($urandom_range(0, 65535)) - 32768)));
      end else begin
        send_item(pen_cmd(coord_t'($urandom()), coord_t'($urandom())));
      end
    end else if (r < 96) begin
      send_item(bare_cmd(CMD_CLEAR));
    end else begin
      send_item(bare_cmd(3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST))));
      counted = 0;
    end
  endtask

  // Wait until every vertex is back and the pipeline has gone quiet
  task automatic drain();
    @(negedge clk);
    glyph_in.valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_TEXT_COLOR:  text_color = data[COLOR_W-1:0];
      REG_FONT_HEIGHT: font_h     = data[METRIC_W-1:0];
      REG_LINE_WIDTH:  line_w     = data[LINE_W-1:0];
      REG_SPACE_WIDTH: space_w    = data[METRIC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_config(input logic [CFG_DATA_W-1:0] color, fh, lw, sw);
    write_reg(REG_TEXT_COLOR, color);
    write_reg(REG_FONT_HEIGHT, fh);
    write_reg(REG_LINE_WIDTH, lw);
    write_reg(REG_SPACE_WIDTH, sw);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int sent;
    int n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      send_random(n);
      sent += n;
    end
  endtask

  // Vertex receiver: random stalls plus one long hold-off on request
  initial begin
    vtx_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        vtx_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      vtx_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Vertex checker: each transaction against the oldest expectation
  always @(posedge clk) begin : vertex_check
    vertex_t got;
    vertex_t want;
    if (rst_n && vtx_out.valid === 1'b1 && vtx_out.ready === 1'b1) begin
      got = '{vtx_out.status, vtx_out.vertex_slot, vtx_out.pos_x, vtx_out.pos_y,
              vtx_out.tex_u, vtx_out.tex_v, vtx_out.color, vtx_out.last};
      if (pending_vertices.size() == 0) begin
        note_mismatch("result with nothing pending, slot", got.slot, 0);
      end else begin
        want = pending_vertices.pop_front();
        if (got.status !== want.status) note_mismatch("status", got.status, want.status);
        if (got.slot !== want.slot) note_mismatch("vertex_slot", got.slot, want.slot);
        if (got.x !== want.x) note_mismatch("pos_x", got.x, want.x);
        if (got.y !== want.y) note_mismatch("pos_y", got.y, want.y);
        if (got.u !== want.u) note_mismatch("tex_u", got.u, want.u);
        if (got.v !== want.v) note_mismatch("tex_v", got.v, want.v);
        if (got.color !== want.color) note_mismatch("color", got.color, want.color);
        if (got.last !== want.last) note_mismatch("last", got.last, want.last);
      end
    end
  end

  // Watchdog: too long without any transaction ends the run
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (glyph_in.valid && glyph_in.ready) ||
        (vtx_out.valid && vtx_out.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t directed[$];
    foreach (metric_set[i]) begin
      metric_set[i] = 1'b0;
      uv_set[i]     = 4'h0;
    end
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_TEXT_COLOR;
    cfg_wdata = '0;
    glyph_in.valid         = 1'b0;
    glyph_in.command       = CMD_CLEAR;
    glyph_in.char_code     = '0;
    glyph_in.pen_x         = '0;
    glyph_in.pen_y         = '0;
    glyph_in.glyph_width   = '0;
    glyph_in.glyph_height  = '0;
    glyph_in.glyph_advance = '0;
    glyph_in.glyph_drop    = '0;
    glyph_in.corner        = '0;
    glyph_in.tex_u_in      = '0;
    glyph_in.tex_v_in      = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table at reset configuration
    directed.push_back('{char_cmd(8'd200), 1'b1, ST_BAD_CODE});
    directed.push_back('{char_cmd(8'd255), 1'b1, ST_BAD_CODE});
    directed.push_back('{char_cmd(8'(GLYPH_COUNT)), 1'b1, ST_BAD_CODE});
    directed.push_back('{metric_cmd(CH_NEWLINE, '0, '0, '0, '0), 1'b0, ST_VERTEX});
    directed.push_back('{metric_cmd(GLYPH_A, 16'h0100, 16'h0200, 16'h0120, 16'h0040),
                         1'b0, ST_VERTEX});
    directed.push_back('{uv_cmd(GLYPH_A, 2'd0, 16'h0000, 16'h0000), 1'b0, ST_VERTEX});
    directed.push_back('{uv_cmd(GLYPH_A, 2'd1, 16'hFFFF, 16'h0000), 1'b0, ST_VERTEX});
    directed.push_back('{uv_cmd(GLYPH_A, 2'd2, 16'hFFFF, 16'hFFFF), 1'b0, ST_VERTEX});
    directed.push_back('{uv_cmd(GLYPH_A, 2'd3, 16'h0000, 16'hFFFF), 1'b0, ST_VERTEX});
    directed.push_back('{metric_cmd(GLYPH_HUGE, '1, '1, '1, '1), 1'b0, ST_VERTEX});
    for (int k = 0; k < 4; k++) begin
      directed.push_back('{uv_cmd(GLYPH_HUGE, 2'(k), UV_W'($urandom()), UV_W'($urandom())),
                           1'b0, ST_VERTEX});
    end
    directed.push_back('{metric_cmd(8'd200, '1, '1, '1, '1), 1'b0, ST_VERTEX});
    directed.push_back('{char_cmd(GLYPH_A), 1'b0, ST_VERTEX});
    directed.push_back('{char_cmd(CH_SPACE), 1'b0, ST_VERTEX});
    directed.push_back('{char_cmd(CH_NEWLINE), 1'b0, ST_VERTEX});
    // pen at the positive rails: right edge clamps, top edge lands on the rail
    directed.push_back('{pen_cmd(coord_t'(COORD_HI), coord_t'(COORD_HI)), 1'b0, ST_VERTEX});
    directed.push_back('{char_cmd(GLYPH_HUGE), 1'b0, ST_VERTEX});
    // pen at the negative rails: bottom clamps, top from the raw bottom
    directed.push_back('{pen_cmd(coord_t'(COORD_LO), coord_t'(COORD_LO)), 1'b0, ST_VERTEX});
    directed.push_back('{char_cmd(GLYPH_HUGE), 1'b0, ST_VERTEX});
    directed.push_back('{char_cmd(CH_NEWLINE), 1'b0, ST_VERTEX});
    directed.push_back('{bare_cmd(CMD_RSVD_LAST), 1'b0, ST_VERTEX});
    directed.push_back('{bare_cmd(CMD_CLEAR), 1'b0, ST_VERTEX});
    directed.push_back('{char_cmd(GLYPH_A), 1'b0, ST_VERTEX});
    foreach (directed[i]) send_item(directed[i].c, directed[i].typed, directed[i].st);

    // A few more glyphs to spread the random picks
    for (int g = 0; g < 6; g++) define_glyph(8'($urandom_range(33, GLYPH_COUNT - 2)));
    drain();

    // Narrow lines, no idling; the receiver holds off to back the block up
    write_config($urandom(), 32'h0180, 32'h01000, 32'h0050);
    hold_req = 1'b1;
    run_phase(0, 0);
    drain();

    // Everything at zero, sender idling
    write_config('0, '0, '0, '0);
    run_phase(61, 0);
    drain();

    // Everything at its top value with wrapping still on, receiver stalling
    write_config(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h7FFFE, 32'h0000_FFFF);
    run_phase(0, 61);
    drain();

    // Random register words, upper bits included; both sides idling
    write_config($urandom(), $urandom(), $urandom(), $urandom());
    run_phase(10, 10);
    drain();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[glyph_quad_layout.f]
+incdir+sv
sv/glq_pkg.sv
sv/glq_ifs.sv
sv/glq_ram.sv
sv/glyph_quad_layout.sv
sv/glq_checker.sv
bench/tb_glyph_quad_layout.sv
